FILE: rtl/gdr_pkg.sv
// Shared constants, types and button map for the game pad debounce and report block.
package gdr_pkg;

    localparam int BUTTONS_PER_PAD = 16;
    localparam int PAD_COUNT       = 4;

    localparam int PAD_SEL_W = 2;
    localparam int PAD_SLOTS = 1 << PAD_SEL_W;
    localparam int LEVEL_W   = 16;
    localparam int COUNT_W   = 8;
    localparam int TOL_W     = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [TOL_W-1:0]   TOL_RESET = 8'd3;

    // Serial bit order of the pad buttons
    localparam int BTN_B      = 0;
    localparam int BTN_Y      = 1;
    localparam int BTN_SELECT = 2;
    localparam int BTN_START  = 3;
    localparam int BTN_UP     = 4;
    localparam int BTN_DOWN   = 5;
    localparam int BTN_LEFT   = 6;
    localparam int BTN_RIGHT  = 7;
    localparam int BTN_A      = 8;
    localparam int BTN_X      = 9;
    localparam int BTN_L      = 10;
    localparam int BTN_R      = 11;

    // Bit positions in the report button word
    localparam int RPT_Y      = 0;
    localparam int RPT_B      = 1;
    localparam int RPT_A      = 2;
    localparam int RPT_X      = 3;
    localparam int RPT_L      = 4;
    localparam int RPT_R      = 5;
    localparam int RPT_START  = 9;
    localparam int RPT_SELECT = 12;

    localparam logic [7:0] AXIS_LOW    = 8'd0;
    localparam logic [7:0] AXIS_HIGH   = 8'd255;
    localparam logic [7:0] AXIS_CENTER = 8'd128;

    typedef enum logic {
        CMD_SCAN   = 1'b0,
        CMD_REPORT = 1'b1
    } cmd_t;

    localparam logic [2:0] ADDR_TOL = 3'd0;

    // Packed so that buttons land in the lowest bits of tdata
    typedef struct packed {
        logic       changed;
        logic [7:0] stick_y;
        logic [7:0] stick_x;
        logic [15:0] buttons;
    } report_t;

    localparam int OUT_DATA_W = 40;

    typedef logic [BUTTONS_PER_PAD-1:0] pad_levels_t;

endpackage

FILE: rtl/gamepad_debounce_report.sv
// A scan updates all debounce state at its accept edge; a report is written at its accept edge
// into the output register that drives m_tvalid, or into the skid entry if it stays full.
// Throughput: one transaction per cycle while s_tready is high; each pad has its own
// debounce lane, all updated at once. s_tready drops only while both the output register
// and its skid entry are full. Reset (rst_n low, asynchronous): levels released, counters
// and last reports zero, tolerance 3, output empty.
module gamepad_debounce_report (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,  // pad0_levels, pad1_levels, pad2_levels, pad3_levels, pad_sel
    input  logic        s_tuser,  // cmd
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata   // buttons, stick_x, stick_y, changed
);

    logic [gdr_pkg::TOL_W-1:0]     tolerance_reg;
    logic                          cfg_write;
    logic                          accept;
    gdr_pkg::cmd_t                 cmd;
    logic [gdr_pkg::PAD_SEL_W-1:0] pad_sel;
    logic                          scan;
    logic                          request;
    logic                          busy;
    gdr_pkg::pad_levels_t          levels [gdr_pkg::PAD_COUNT];
    gdr_pkg::report_t              report;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tolerance_reg <= gdr_pkg::TOL_RESET;
        else if (cfg_write && (paddr == gdr_pkg::ADDR_TOL))
            tolerance_reg <= pwdata[gdr_pkg::TOL_W-1:0];
    end

    assign prdata = (paddr == gdr_pkg::ADDR_TOL)
                  ? {{(32 - gdr_pkg::TOL_W){1'b0}}, tolerance_reg} : '0;

    assign s_tready = !busy;
    assign accept   = s_tvalid && s_tready;
    assign cmd      = gdr_pkg::cmd_t'(s_tuser);
    assign pad_sel  = s_tdata[4*gdr_pkg::LEVEL_W +: gdr_pkg::PAD_SEL_W];
    assign scan     = accept && (cmd == gdr_pkg::CMD_SCAN);
    assign request  = accept && (cmd == gdr_pkg::CMD_REPORT);

    for (genvar p = 0; p < gdr_pkg::PAD_COUNT; p++) begin : g_lane
        gdr_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .scan      (scan),
            .raw       (s_tdata[p*gdr_pkg::LEVEL_W +: gdr_pkg::BUTTONS_PER_PAD]),
            .tolerance (tolerance_reg),
            .level     (levels[p])
        );
    end

    gdr_report u_report (
        .clk        (clk),
        .rst_n      (rst_n),
        .request    (request),
        .pad_sel    (pad_sel),
        .levels     (levels),
        .busy       (busy),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_report (report)
    );

    assign m_tdata = {{(gdr_pkg::OUT_DATA_W - $bits(gdr_pkg::report_t)){1'b0}}, report};

endmodule

FILE: rtl/gdr_lane.sv
// One pad lane: per-button debounce counters and debounced levels.
module gdr_lane (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                scan,
    input  logic [gdr_pkg::BUTTONS_PER_PAD-1:0] raw,
    input  logic [gdr_pkg::TOL_W-1:0]           tolerance,
    output gdr_pkg::pad_levels_t                level
);

    for (genvar b = 0; b < gdr_pkg::BUTTONS_PER_PAD; b++) begin : g_btn
        logic                         level_reg;
        logic                         level_next;
        logic [gdr_pkg::COUNT_W-1:0]  count_reg;
        logic [gdr_pkg::COUNT_W-1:0]  count_next;

        always_comb
        begin
            level_next = level_reg;
            count_next = count_reg;
            if (raw[b] != level_reg)
            begin
                if (count_reg > tolerance)
                begin
                    // flip and clear, levels now agree
                    level_next = raw[b];
                    count_next = '0;
                end
                else if (count_reg != gdr_pkg::COUNT_MAX)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            else
            begin
                count_next = '0;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                level_reg <= 1'b1;
                count_reg <= '0;
            end
            else if (scan)
            begin
                level_reg <= level_next;
                count_reg <= count_next;
            end
        end

        assign level[b] = level_reg;
    end

endmodule

FILE: rtl/gdr_report.sv
// Merge stage: builds the report of the selected pad and buffers it for the output stream.
module gdr_report (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             request,
    input  logic [gdr_pkg::PAD_SEL_W-1:0]    pad_sel,
    input  gdr_pkg::pad_levels_t             levels [gdr_pkg::PAD_COUNT],
    output logic                             busy,
    output logic                             out_valid,
    input  logic                             out_ready,
    output gdr_pkg::report_t                 out_report
);

    gdr_pkg::pad_levels_t slot_levels [gdr_pkg::PAD_SLOTS];
    gdr_pkg::pad_levels_t lv;
    gdr_pkg::report_t     rpt;
    logic                 sel_ok;
    logic                 push;
    logic                 pop;

    logic [15:0] last_buttons_reg [gdr_pkg::PAD_SLOTS];
    logic [7:0]  last_x_reg       [gdr_pkg::PAD_SLOTS];
    logic [7:0]  last_y_reg       [gdr_pkg::PAD_SLOTS];

    gdr_pkg::report_t out_reg;
    gdr_pkg::report_t skid_reg;
    logic             out_valid_reg;
    logic             skid_valid_reg;

    // Slots without a pad read as released
    for (genvar p = 0; p < gdr_pkg::PAD_SLOTS; p++) begin : g_slot
        if (p < gdr_pkg::PAD_COUNT) begin : g_used
            assign slot_levels[p] = levels[p];
        end
        else begin : g_unused
            assign slot_levels[p] = '1;
        end
    end

    assign sel_ok = ({1'b0, pad_sel} < (gdr_pkg::PAD_SEL_W + 1)'(gdr_pkg::PAD_COUNT));
    assign push   = request && sel_ok;
    assign lv     = slot_levels[pad_sel];

    always_comb
    begin
        rpt = '0;
        rpt.buttons[gdr_pkg::RPT_Y]      = !lv[gdr_pkg::BTN_Y];
        rpt.buttons[gdr_pkg::RPT_B]      = !lv[gdr_pkg::BTN_B];
        rpt.buttons[gdr_pkg::RPT_A]      = !lv[gdr_pkg::BTN_A];
        rpt.buttons[gdr_pkg::RPT_X]      = !lv[gdr_pkg::BTN_X];
        rpt.buttons[gdr_pkg::RPT_L]      = !lv[gdr_pkg::BTN_L];
        rpt.buttons[gdr_pkg::RPT_R]      = !lv[gdr_pkg::BTN_R];
        rpt.buttons[gdr_pkg::RPT_START]  = !lv[gdr_pkg::BTN_START];
        rpt.buttons[gdr_pkg::RPT_SELECT] = !lv[gdr_pkg::BTN_SELECT];
        if (!lv[gdr_pkg::BTN_LEFT])
            rpt.stick_x = gdr_pkg::AXIS_LOW;
        else if (!lv[gdr_pkg::BTN_RIGHT])
            rpt.stick_x = gdr_pkg::AXIS_HIGH;
        else
            rpt.stick_x = gdr_pkg::AXIS_CENTER;
        if (!lv[gdr_pkg::BTN_UP])
            rpt.stick_y = gdr_pkg::AXIS_LOW;
        else if (!lv[gdr_pkg::BTN_DOWN])
            rpt.stick_y = gdr_pkg::AXIS_HIGH;
        else
            rpt.stick_y = gdr_pkg::AXIS_CENTER;
        rpt.changed = (rpt.buttons != last_buttons_reg[pad_sel])
                   || (rpt.stick_x != last_x_reg[pad_sel])
                   || (rpt.stick_y != last_y_reg[pad_sel]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < gdr_pkg::PAD_SLOTS; i++)
            begin
                last_buttons_reg[i] <= '0;
                last_x_reg[i]       <= '0;
                last_y_reg[i]       <= '0;
            end
        end
        else if (push)
        begin
            last_buttons_reg[pad_sel] <= rpt.buttons;
            last_x_reg[pad_sel]       <= rpt.stick_x;
            last_y_reg[pad_sel]       <= rpt.stick_y;
        end
    end

    assign pop = out_valid_reg && out_ready;

    // Output register plus one skid entry; input stalls only while the skid is full
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_reg <= skid_reg;
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
                out_reg <= rpt;
            else
                skid_reg <= rpt;
        end
    end

    assign busy       = skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_report = out_reg;

    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_no_push_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !push)
        else $error("report accepted while skid entry full");

    a_push_empty_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !out_valid_reg) |=> (out_valid_reg && !skid_valid_reg))
        else $error("report into empty buffer not presented");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && skid_valid_reg) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid entry not moved to output register");

endmodule

FILE: tb/gamepad_debounce_report_test.sv
// Self-checking testbench for the game pad debounce and report block.
`timescale 1ns / 1ps

module gamepad_debounce_report_test;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 10;
    localparam logic [2:0] ADDR_SPARE = 3'd4;

    localparam gdr_pkg::cmd_t SCAN   = gdr_pkg::CMD_SCAN;
    localparam gdr_pkg::cmd_t REPORT = gdr_pkg::CMD_REPORT;
    localparam logic [7:0]    MID    = gdr_pkg::AXIS_CENTER;
    localparam logic [7:0]    LOW    = gdr_pkg::AXIS_LOW;

    localparam logic [63:0] ALL_UP    = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ALL_DOWN  = 64'h0000_0000_0000_0000;
    localparam logic [63:0] DOWN_RGT  = {4{16'hFF5F}};
    localparam logic [63:0] ALL_DIRS  = {4{16'hFF0F}};
    localparam logic [63:0] HIGH_ONLY = {4{16'h0FFF}};
    localparam logic [63:0] MIXED     = 64'hFFFF_0000_5555_AAAA;

    typedef struct packed {
        gdr_pkg::cmd_t cmd;
        logic [3:0]    reps;
        logic [63:0]   levels;
        logic [1:0]    pad;
        logic          typed;
        logic [15:0]   want_buttons;
        logic [7:0]    want_x;
        logic [7:0]    want_y;
        logic          want_changed;
    } stim_row_t;

    typedef struct {
        int tol;
        int items;
        int change_pct;
        int noise_pct;
        int report_pct;
    } phase_t;

    localparam int DIR_ROWS = 20;
    localparam int TOL0_ROW = 7;  // drop tolerance to zero before this row

    stim_row_t directed_rows [DIR_ROWS] = '{
        '{REPORT, 4'd1, ALL_UP,    2'd0, 1'b1, 16'h0000, MID, MID, 1'b1},
        '{REPORT, 4'd1, ALL_UP,    2'd3, 1'b1, 16'h0000, MID, MID, 1'b1},
        '{REPORT, 4'd1, ALL_UP,    2'd0, 1'b1, 16'h0000, MID, MID, 1'b0},
        '{SCAN,   4'd4, ALL_DOWN,  2'd0, 1'b0, 16'h0000, 8'd0, 8'd0, 1'b0},
        '{REPORT, 4'd1, ALL_UP,    2'd1, 1'b1, 16'h0000, MID, MID, 1'b1},
        '{SCAN,   4'd1, ALL_DOWN,  2'd0, 1'b0, 16'h0000, 8'd0, 8'd0, 1'b0},
        '{REPORT, 4'd1, ALL_UP,    2'd0, 1'b1, 16'h123F, LOW, LOW, 1'b1},
        '{SCAN,   4'd1, ALL_UP,    2'd0, 1'b0, 16'h0000, 8'd0, 8'd0, 1'b0},
        '{SCAN,   4'd1, ALL_DOWN,  2'd0, 1'b0, 16'h0000, 8'd0, 8'd0, 1'b0},
        '{SCAN,   4'd1, ALL_UP,    2'd0, 1'b0, 16'h0000, 8'd0, 8'd0, 1'b0},
        '{REPORT, 4'd1, ALL_UP,    2'd2, 1'b0, 16'h0000, 8'd0, 8'd0, 1'b0},
        '{SCAN,   4'd2, DOWN_RGT,  2'd0, 1'b0, 16'h0000, 8'd0, 8'd0, 1'b0},
        '{REPORT, 4'd1, ALL_UP,    2'd1, 1'b0, 16'h0000, 8'd0, 8'd0, 1'b0},
        '{SCAN,   4'd2, ALL_DIRS,  2'd0, 1'b0, 16'h0000, 8'd0, 8'd0, 1'b0},
        '{REPORT, 4'd1, ALL_UP,    2'd2, 1'b0, 16'h0000, 8'd0, 8'd0, 1'b0},
        '{SCAN,   4'd2, HIGH_ONLY, 2'd0, 1'b0, 16'h0000, 8'd0, 8'd0, 1'b0},
        '{REPORT, 4'd1, ALL_UP,    2'd3, 1'b0, 16'h0000, 8'd0, 8'd0, 1'b0},
        '{SCAN,   4'd2, MIXED,     2'd0, 1'b0, 16'h0000, 8'd0, 8'd0, 1'b0},
        '{REPORT, 4'd1, ALL_UP,    2'd0, 1'b0, 16'h0000, 8'd0, 8'd0, 1'b0},
        '{REPORT, 4'd1, ALL_UP,    2'd1, 1'b0, 16'h0000, 8'd0, 8'd0, 1'b0}
    };

    localparam int PHASES = 6;
    phase_t phases [PHASES] = '{
        '{0,   250, 20, 10, 30},
        '{1,   250, 15, 15, 30},
        '{255, 320, 0,  0,  8},
        '{254, 320, 0,  0,  8},
        '{7,   200, 10, 10, 25},
        '{2,   180, 25, 20, 35}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;  // pad0_levels, pad1_levels, pad2_levels, pad3_levels, pad_sel
    logic        s_tuser = 1'b0;  // cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;  // buttons, stick_x, stick_y, changed

    gamepad_debounce_report DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Debounce state as the block should hold it
    logic [7:0]                  tolerance;
    logic [gdr_pkg::LEVEL_W-1:0] debounced [gdr_pkg::PAD_SLOTS];
    logic [gdr_pkg::COUNT_W-1:0] bounce_cnt [gdr_pkg::PAD_SLOTS][gdr_pkg::LEVEL_W];
    gdr_pkg::report_t            prev_report [gdr_pkg::PAD_SLOTS];

    gdr_pkg::report_t pending_reports [$];
    int               error_count;
    int               scans_sent;
    int               requests_sent;
    int               reports_checked;
    int               stall_cycles;
    bit               send_steady;
    gdr_pkg::report_t got_rpt;
    gdr_pkg::report_t want_rpt;

    task automatic note_error(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("ERROR @%0t: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        error_count++;
    endtask

    function automatic void clear_model();
        tolerance = gdr_pkg::TOL_RESET;
        for (int p = 0; p < gdr_pkg::PAD_SLOTS; p++)
        begin
            debounced[p] = '1;
            prev_report[p] = '0;
            for (int b = 0; b < gdr_pkg::LEVEL_W; b++)
                bounce_cnt[p][b] = '0;
        end
    endfunction

    function automatic void debounce_scan(input logic [63:0] levels);
        logic raw;
        for (int p = 0; p < gdr_pkg::PAD_COUNT; p++)
            for (int b = 0; b < gdr_pkg::BUTTONS_PER_PAD; b++)
            begin
                raw = levels[gdr_pkg::LEVEL_W*p + b];
                if (raw != debounced[p][b])
                begin
                    if (bounce_cnt[p][b] > tolerance)
                        debounced[p][b] = raw;
                    else if (bounce_cnt[p][b] != gdr_pkg::COUNT_MAX)
                        bounce_cnt[p][b] = bounce_cnt[p][b] + 1'b1;
                end
                if (raw == debounced[p][b])
                    bounce_cnt[p][b] = '0;
            end
    endfunction

    function automatic gdr_pkg::report_t build_report(input logic [1:0] pad);
        gdr_pkg::report_t            r;
        logic [gdr_pkg::LEVEL_W-1:0] down;
        r = '0;
        down = ~debounced[pad];
        r.buttons[gdr_pkg::RPT_Y]      = down[gdr_pkg::BTN_Y];
        r.buttons[gdr_pkg::RPT_B]      = down[gdr_pkg::BTN_B];
        r.buttons[gdr_pkg::RPT_A]      = down[gdr_pkg::BTN_A];
        r.buttons[gdr_pkg::RPT_X]      = down[gdr_pkg::BTN_X];
        r.buttons[gdr_pkg::RPT_L]      = down[gdr_pkg::BTN_L];
        r.buttons[gdr_pkg::RPT_R]      = down[gdr_pkg::BTN_R];
        r.buttons[gdr_pkg::RPT_START]  = down[gdr_pkg::BTN_START];
        r.buttons[gdr_pkg::RPT_SELECT] = down[gdr_pkg::BTN_SELECT];
        r.stick_x = down[gdr_pkg::BTN_LEFT] ? gdr_pkg::AXIS_LOW
                  : (down[gdr_pkg::BTN_RIGHT] ? gdr_pkg::AXIS_HIGH : gdr_pkg::AXIS_CENTER);
        r.stick_y = down[gdr_pkg::BTN_UP] ? gdr_pkg::AXIS_LOW
                  : (down[gdr_pkg::BTN_DOWN] ? gdr_pkg::AXIS_HIGH : gdr_pkg::AXIS_CENTER);
        r.changed = (r.buttons != prev_report[pad].buttons) ||
                    (r.stick_x != prev_report[pad].stick_x) ||
                    (r.stick_y != prev_report[pad].stick_y);
        prev_report[pad] = r;
        return r;
    endfunction

    // Send one item; on acceptance advance the model and queue the report it owes
    task automatic send_item(input gdr_pkg::cmd_t cmd, input logic [63:0] levels,
                             input logic [1:0] pad, input bit typed,
                             input gdr_pkg::report_t want);
        int               gap;
        gdr_pkg::report_t predicted;
        if ($urandom_range(0, 39) == 0)
            send_steady = !send_steady;
        gap = send_steady ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'b0, pad, levels};
        do
            @(posedge clk);
        while (!s_tready);
        if (cmd == gdr_pkg::CMD_SCAN)
        begin
            debounce_scan(levels);
            scans_sent++;
        end
        else if (pad < gdr_pkg::PAD_COUNT)
        begin
            predicted = build_report(pad);
            pending_reports.push_back(typed ? want : predicted);
            requests_sent++;
        end
    endtask

    // Drop valid, then hold until every queued report has left
    task automatic wait_reports_done();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Write a register once the block is idle, then read the tolerance back
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        logic [31:0] rd;
        wait_reports_done();
        repeat (2) @(posedge clk);
        apb_access(1'b1, addr, value, rd);
        if (addr == gdr_pkg::ADDR_TOL)
            tolerance = value[7:0];
        apb_access(1'b0, gdr_pkg::ADDR_TOL, '0, rd);
        if (rd !== 32'(tolerance))
            note_error("tolerance readback", rd, 32'(tolerance));
    endtask

    task automatic run_phase(input phase_t ph);
        logic [15:0] target [gdr_pkg::PAD_SLOTS];
        logic [63:0] levels;
        logic [15:0] lv;
        for (int p = 0; p < gdr_pkg::PAD_SLOTS; p++)
            target[p] = 16'($urandom);
        for (int i = 0; i < ph.items; i++)
        begin
            if (i == ph.items / 2)
                wait_reports_done();
            if ($urandom_range(0, 99) < ph.report_pct)
            begin
                send_item(gdr_pkg::CMD_REPORT, {$urandom, $urandom}, 2'($urandom_range(0, 3)),
                          1'b0, '0);
            end
            else
            begin
                for (int p = 0; p < gdr_pkg::PAD_SLOTS; p++)
                begin
                    // hold a target pattern across scans so levels settle, then move it
                    if ($urandom_range(0, 99) < ph.change_pct)
                    begin
                        case ($urandom_range(0, 3))
                            0: target[p] = 16'($urandom);
                            1: target[p] = target[p] ^ (16'd1 << $urandom_range(0, 15));
                            2: target[p] = 16'h0000;
                            default: target[p] = 16'hFFFF;
                        endcase
                    end
                    lv = target[p];
                    if ($urandom_range(0, 99) < ph.noise_pct)
                        lv = lv ^ (16'd1 << $urandom_range(0, 15));
                    levels[gdr_pkg::LEVEL_W*p +: gdr_pkg::LEVEL_W] = lv;
                end
                send_item(gdr_pkg::CMD_SCAN, levels, 2'($urandom_range(0, 3)), 1'b0, '0);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_rpt = gdr_pkg::report_t'(m_tdata[32:0]);
            if (pending_reports.size() == 0)
                note_error("report with none pending", m_tdata[31:0], '0);
            else
            begin
                want_rpt = pending_reports.pop_front();
                if (got_rpt.buttons !== want_rpt.buttons)
                    note_error("buttons", 32'(got_rpt.buttons), 32'(want_rpt.buttons));
                if (got_rpt.stick_x !== want_rpt.stick_x)
                    note_error("stick_x", 32'(got_rpt.stick_x), 32'(want_rpt.stick_x));
                if (got_rpt.stick_y !== want_rpt.stick_y)
                    note_error("stick_y", 32'(got_rpt.stick_y), 32'(want_rpt.stick_y));
                if (got_rpt.changed !== want_rpt.changed)
                    note_error("changed", 32'(got_rpt.changed), 32'(want_rpt.changed));
            end
            reports_checked++;
        end
    end

    initial
    begin : report_sink
        int gap;
        bit steady;
        steady = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                steady = !steady;
            gap = steady ? 0 : $urandom_range(0, 12);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    initial
    begin : watchdog
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("ERROR: no transaction for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : main
        stim_row_t        row;
        logic [31:0]      rd;
        gdr_pkg::report_t want;
        error_count = 0;
        scans_sent = 0;
        requests_sent = 0;
        reports_checked = 0;
        send_steady = 1'b0;
        clear_model();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apb_access(1'b0, gdr_pkg::ADDR_TOL, '0, rd);
        if (rd !== 32'(gdr_pkg::TOL_RESET))
            note_error("tolerance after reset", rd, 32'(gdr_pkg::TOL_RESET));

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            row = directed_rows[r];
            if (r == TOL0_ROW)
                write_reg(gdr_pkg::ADDR_TOL, 32'd0);
            want = '0;
            want.buttons = row.want_buttons;
            want.stick_x = row.want_x;
            want.stick_y = row.want_y;
            want.changed = row.want_changed;
            repeat (row.reps)
                send_item(row.cmd, row.levels, row.pad, row.typed, want);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            // a write past the register list must leave the tolerance alone
            if (ph == 2)
                write_reg(ADDR_SPARE, 32'hA5);
            write_reg(gdr_pkg::ADDR_TOL, 32'(phases[ph].tol));
            run_phase(phases[ph]);
        end

        wait_reports_done();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_reports.size() != 0)
            note_error("reports never delivered", pending_reports.size(), 0);

        $display("Sent %0d scans and %0d report requests; %0d reports checked.",
                 scans_sent, requests_sent, reports_checked);
        $display("Tolerances covered: reset value, 0, 1, 2, 7, 254 and 255 (saturation).");
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: gamepad_debounce_report.f
rtl/gdr_pkg.sv
rtl/gdr_lane.sv
rtl/gdr_report.sv
rtl/gamepad_debounce_report.sv
tb/gamepad_debounce_report_test.sv
